@@ src/rps_pkg.sv @@
// shared types and constants for the permutation shuffler
// no dependencies
package rps_pkg;
	localparam int unsigned StoreDepthDef = 16384;
	localparam int unsigned FieldW = 15;
	localparam int unsigned WordW = 32;
	localparam logic [FieldW-1:0] LengthReset = 15'd10000;
	localparam logic [WordW-1:0] RandMaxReset = 32'h7fff_ffff;

	typedef enum logic {
		CMD_WORD = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_LENGTH = 1'b0,
		CFG_RMAX = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV1,
		ST_CHECK,
		ST_DIV2,
		ST_RD_J,
		ST_RD_I,
		ST_WR_J,
		ST_WR_I,
		ST_RD_POS,
		ST_RD_WAIT,
		ST_OUT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic start;
		logic [WordW-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [FieldW:0] rem;
	} div_rsp_t;
endpackage

@@ src/random_permutation_shuffler_unit.sv @@
// Fisher-Yates shuffle engine over a one-based permutation store.
// Input channel s_axis: tuser = command, tdata = {read_position, random_word}.
// Output channel m_axis: tdata = {read_value, pass_done, swap_high_position,
// swap_low_position, accepted}. Config: cfg_we/cfg_index/cfg_data.
// Reset: clears control, then runs a clearing pass writing identity into the
// store at addresses 0 through STORE_DEPTH, during which s_axis_tready stays low.
// An accepted word gives its result after two remainder runs of the shared
// bit-serial divider (rejection limit, then position) plus two reads and two
// writes of the store. A rejected word gives its result after the first
// divider run and the limit check, a word under a short length directly, and
// a read after one store read. One transaction at a time; the result sits in
// an output register until m_axis_tready, and the next input is taken in the
// cycle after it leaves.
// Rejected words and short lengths yield an all-zero result.
// Depends on rps_pkg, rps_divider, rps_store.
module random_permutation_shuffler_unit
	import rps_pkg::*;
#(
	parameter int unsigned STORE_DEPTH = StoreDepthDef,
	localparam int unsigned AddrW = $clog2(STORE_DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [47:0] s_axis_tdata, // random_word, read_position, pad
	input logic s_axis_tuser, // command
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // accepted, swap_low, swap_high, pass_done, read_value, pad
	input logic cfg_we,
	input logic cfg_index,
	input logic [WordW-1:0] cfg_data
);
	state_t state_q, state_d;
	logic [FieldW-1:0] len_q;
	logic [WordW-1:0] rmax_q;
	logic [AddrW-1:0] ptr_q;
	logic [WordW-1:0] word_q;
	logic [FieldW-1:0] pos_q;
	logic [AddrW-1:0] j_q, vj_q, clr_q;
	logic [47:0] out_q;
	logic outv_q;
	logic [AddrW:0] neff;
	logic [AddrW-1:0] iuse;
	div_req_t dreq;
	div_rsp_t drsp;
	logic [AddrW-1:0] rdata, raddr, waddr, wdata;
	logic we;
	logic [WordW-1:0] limit;
	logic [AddrW:0] jsum;

	assign neff = (WordW'(len_q) > WordW'(STORE_DEPTH)) ? (AddrW+1)'(STORE_DEPTH)
		: (AddrW+1)'(len_q);
	assign iuse = ptr_q;
	assign limit = rmax_q - WordW'(drsp.rem);
	assign jsum = (AddrW+1)'(drsp.rem) + 1'b1;

	rps_divider #(.DivW(AddrW + 1)) u_div (
		.clk, .arst_n, .req(dreq), .divisor({1'b0, iuse}), .rsp(drsp)
	);

	rps_store #(.Depth(STORE_DEPTH), .AddrW(AddrW)) u_store (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == AddrW'(STORE_DEPTH)) state_d = ST_IDLE;
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == CMD_READ) state_d = ST_RD_POS;
				else if (neff < (AddrW+1)'(2)) state_d = ST_OUT;
				else state_d = ST_DIV1;
			end
			ST_DIV1: if (drsp.done) state_d = ST_CHECK;
			ST_CHECK: state_d = (word_q >= limit) ? ST_OUT : ST_DIV2;
			ST_DIV2: if (drsp.done) state_d = ST_RD_J;
			ST_RD_J: state_d = ST_RD_I;
			ST_RD_I: state_d = ST_WR_J;
			ST_WR_J: state_d = ST_WR_I;
			ST_WR_I: state_d = ST_OUT;
			ST_RD_POS: state_d = ST_RD_WAIT;
			ST_RD_WAIT: state_d = ST_OUT;
			ST_OUT: if (!outv_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = rmax_q;
		we = 1'b0;
		waddr = clr_q;
		wdata = clr_q;
		raddr = j_q;
		unique case (state_q)
			ST_CLEAR: we = 1'b1;
			ST_CHECK: begin
				dreq.start = (word_q < limit);
				dreq.dividend = word_q;
			end
			ST_RD_J: raddr = j_q;
			ST_RD_I: raddr = iuse;
			ST_WR_J: begin
				we = 1'b1; waddr = j_q; wdata = rdata;
			end
			ST_WR_I: begin
				we = 1'b1; waddr = iuse; wdata = vj_q;
			end
			ST_RD_POS: raddr = AddrW'(pos_q);
			default: ;
		endcase
		if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready
			&& s_axis_tuser == CMD_WORD && neff >= (AddrW+1)'(2))
			dreq.start = 1'b1;
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !outv_q;
	assign m_axis_tvalid = outv_q;
	assign m_axis_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			len_q <= LengthReset;
			rmax_q <= RandMaxReset;
			ptr_q <= '0;
			outv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				if (cfg_index == CFG_LENGTH) len_q <= cfg_data[FieldW-1:0];
				else rmax_q <= cfg_data;
			end
			if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready
				&& s_axis_tuser == CMD_WORD && neff >= (AddrW+1)'(2)
				&& ptr_q <= AddrW'(1))
				ptr_q <= neff[AddrW-1:0];
			if (state_q == ST_WR_I) ptr_q <= ptr_q - 1'b1;
			if (outv_q && m_axis_tready) outv_q <= 1'b0;
			if (state_q == ST_OUT && !outv_q) outv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
			word_q <= s_axis_tdata[WordW-1:0];
			pos_q <= s_axis_tdata[WordW+FieldW-1:WordW];
			out_q <= '0;
		end
		if (state_q == ST_DIV2 && drsp.done) j_q <= jsum[AddrW-1:0];
		if (state_q == ST_RD_I) vj_q <= rdata;
		if (state_q == ST_WR_I) begin
			out_q[0] <= 1'b1;
			out_q[15:1] <= FieldW'(j_q);
			out_q[30:16] <= FieldW'(iuse);
			out_q[31] <= (iuse == AddrW'(2));
		end
		if (state_q == ST_RD_WAIT && pos_q != '0 && WordW'(pos_q) <= WordW'(STORE_DEPTH))
			out_q[46:32] <= FieldW'(rdata);
	end
endmodule

@@ src/rps_divider.sv @@
// iterative restoring divider, one quotient bit a cycle, remainder only
// depends on rps_pkg
module rps_divider
	import rps_pkg::*;
#(
	parameter int unsigned DivW = FieldW + 1
) (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	input logic [DivW-1:0] divisor,
	output div_rsp_t rsp
);
	logic [WordW-1:0] dvd_q;
	logic [DivW:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DivW:0] shifted;
	logic [DivW:0] diff;

	assign shifted = {rem_q[DivW-1:0], dvd_q[WordW-1]};
	assign diff = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(WordW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WordW-2:0], 1'b0};
			rem_q <= diff[DivW] ? shifted : diff;
		end
	end

	assign rsp = {done_q, rem_q[FieldW:0]};
endmodule

@@ src/rps_store.sv @@
// permutation store, synchronous memory with registered read data
// depends on rps_pkg
module rps_store
	import rps_pkg::*;
#(
	parameter int unsigned Depth = StoreDepthDef,
	parameter int unsigned AddrW = $clog2(Depth + 1)
) (
	input logic clk,
	input logic we,
	input logic [AddrW-1:0] waddr,
	input logic [AddrW-1:0] wdata,
	input logic [AddrW-1:0] raddr,
	output logic [AddrW-1:0] rdata
);
	logic [AddrW-1:0] mem [0:Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ src/rps_checker.sv @@
// port-level checks for the shuffler
// depends on random_permutation_shuffler_unit
module rps_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");
	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[15:1] <= m_axis_tdata[30:16])
		else $error("swap low above high");
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[0]) else $error("pass without swap");
endmodule

bind random_permutation_shuffler_unit rps_checker u_chk (
	.clk, .arst_n, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
	.m_axis_tdata
);

@@ dv/testbench.sv @@
// self-checking testbench for random_permutation_shuffler_unit
// holds a shuffle predictor in a small scoreboard class, drives streams with bursts and stalls
// depends on rps_pkg and the shuffler rtl
module testbench;
	import rps_pkg::*;

	localparam int unsigned Depth = StoreDepthDef;
	localparam int unsigned StallLimit = 60000;

	class shuffle_scoreboard;
		logic [FieldW-1:0] perm [0:Depth];
		logic [FieldW-1:0] ptr;
		logic [FieldW-1:0] len;
		logic [WordW-1:0] rmax;
		logic [47:0] pending [$];
		int errors;
		int swaps;
		int passes;
		int reads;

		function new();
			for (int k = 0; k <= Depth; k++) perm[k] = FieldW'(k);
			ptr = '0;
			len = LengthReset;
			rmax = RandMaxReset;
			errors = 0;
			swaps = 0;
			passes = 0;
			reads = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [WordW-1:0] val);
			if (idx == CFG_LENGTH) len = val[FieldW-1:0];
			else rmax = val;
		endfunction

		function void note_input(cmd_t cmd, logic [WordW-1:0] word, logic [FieldW-1:0] pos);
			logic [47:0] r;
			int unsigned n, i, j, lim;
			logic [FieldW-1:0] t;
			r = '0;
			if (cmd == CMD_READ) begin
				reads++;
				if (pos >= 1 && pos <= Depth) r[46:32] = perm[pos];
			end else begin
				n = (len > Depth) ? Depth : len;
				if (n >= 2) begin
					if (ptr <= 1) ptr = FieldW'(n);
					i = ptr;
					lim = rmax - (rmax % i);
					if (word < lim) begin
						j = (word % i) + 1;
						t = perm[j];
						perm[j] = perm[i];
						perm[i] = t;
						ptr = FieldW'(i - 1);
						r[0] = 1'b1;
						r[15:1] = FieldW'(j);
						r[30:16] = FieldW'(i);
						r[31] = (ptr == 1);
						swaps++;
						if (ptr == 1) passes++;
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [47:0] got);
			logic [47:0] e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got[0] !== e[0]) begin
				$display("%0t: accepted exp %0d got %0d", $time, e[0], got[0]);
				errors++;
			end
			if (got[15:1] !== e[15:1]) begin
				$display("%0t: swap_low exp %0d got %0d", $time, e[15:1], got[15:1]);
				errors++;
			end
			if (got[30:16] !== e[30:16]) begin
				$display("%0t: swap_high exp %0d got %0d", $time, e[30:16], got[30:16]);
				errors++;
			end
			if (got[31] !== e[31]) begin
				$display("%0t: pass_done exp %0d got %0d", $time, e[31], got[31]);
				errors++;
			end
			if (got[46:32] !== e[46:32]) begin
				$display("%0t: read_value exp %0d got %0d", $time, e[46:32], got[46:32]);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata; // random_word, read_position, pad
	logic s_axis_tuser; // command
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata; // accepted, swap_low, swap_high, pass_done, read_value, pad
	logic cfg_we;
	logic cfg_index;
	logic [WordW-1:0] cfg_data;

	shuffle_scoreboard sb;
	int idle_cycles;
	int sent;
	int stall_mode;

	random_permutation_shuffler_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(cmd_t cmd, logic [WordW-1:0] word, logic [FieldW-1:0] pos);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = cmd;
		s_axis_tdata = {1'b0, pos, word};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(cmd, word, pos);
		sent++;
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// wait for the block to drain, then write one register
	task automatic write_reg(cfg_idx_t idx, logic [WordW-1:0] val);
		pause_sender(0);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_item(int unsigned n, logic [WordW-1:0] rmax);
		logic [WordW-1:0] w;
		logic [FieldW-1:0] p;
		if ($urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 7) == 0) p = FieldW'($urandom_range(0, 32767));
			else p = FieldW'($urandom_range(0, n + 1));
			send_item(CMD_READ, $urandom, p);
		end else begin
			if (rmax < 1000 && $urandom_range(0, 7) != 0)
				w = $urandom_range(0, rmax + rmax / 8 + 1);
			else w = $urandom;
			send_item(CMD_WORD, w, FieldW'($urandom));
		end
	endtask

	// receiver stall pattern, switches mode now and then
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready = 1'b1;
			1: m_axis_tready = ($urandom_range(0, 1) == 0);
			2: m_axis_tready = ($urandom_range(0, 9) == 0);
			default: m_axis_tready = ~m_axis_tready;
		endcase
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cycles);
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		logic [WordW-1:0] rmax;
		int count;
		int burst;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_WORD;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LENGTH;
		cfg_data = '0;
		idle_cycles = 0;
		sent = 0;
		stall_mode = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reads at the edges, words with default registers
		send_item(CMD_READ, 32'h0, 15'd0);
		send_item(CMD_READ, 32'hffff_ffff, 15'd1);
		send_item(CMD_READ, 32'h0, 15'd16384);
		send_item(CMD_READ, 32'h0, 15'd16385);
		send_item(CMD_READ, 32'h0, 15'h7fff);
		send_item(CMD_WORD, 32'h0, 15'h7fff);
		send_item(CMD_WORD, 32'hffff_ffff, 15'd0);
		send_item(CMD_WORD, 32'h7fff_fffe, 15'd0);
		send_item(CMD_READ, 32'h0, 15'd10000);
		// short lengths ignore words
		write_reg(CFG_LENGTH, 32'd1);
		send_item(CMD_WORD, 32'd5, 15'd0);
		write_reg(CFG_LENGTH, 32'd0);
		send_item(CMD_WORD, 32'd6, 15'd0);
		// length changed mid-pass, words continue the old pass
		write_reg(CFG_LENGTH, 32'd2);
		write_reg(CFG_RMAX, 32'hffff_ffff);
		send_item(CMD_WORD, 32'd1, 15'd0);
		send_item(CMD_WORD, 32'd0, 15'd0);
		send_item(CMD_WORD, 32'hffff_ffff, 15'd0);
		send_item(CMD_READ, 32'd0, 15'd1);
		send_item(CMD_READ, 32'd0, 15'd2);
		// saturated length
		write_reg(CFG_LENGTH, 32'd20000);
		send_item(CMD_WORD, 32'd12345, 15'd0);
		send_item(CMD_READ, 32'd0, 15'd16384);
		// zero limit rejects all, a limit of one too
		write_reg(CFG_RMAX, 32'd0);
		send_item(CMD_WORD, 32'd0, 15'd0);
		write_reg(CFG_RMAX, 32'd1);
		send_item(CMD_WORD, 32'd0, 15'd0);
		write_reg(CFG_LENGTH, 32'd16384);
		send_item(CMD_WORD, 32'd0, 15'd0);

		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 7))
				0: n = 16384;
				1: n = $urandom_range(16385, 32767);
				2: n = $urandom_range(0, 1);
				default: n = $urandom_range(2, 40);
			endcase
			case ($urandom_range(0, 4))
				0: rmax = 32'hffff_ffff;
				1: rmax = $urandom;
				2: rmax = $urandom_range(1, 200);
				3: rmax = (ph == 5) ? 32'd0 : $urandom_range(n, 5 * n + 3);
				default: rmax = RandMaxReset;
			endcase
			if (ph == 0) rmax = 32'hffff_ffff;
			if (n < 2) count = 10;
			else count = 135;
			write_reg(CFG_LENGTH, n);
			write_reg(CFG_RMAX, rmax);
			while (count > 0) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && count > 0; b++) begin
					random_item(n < 2 ? 10 : (n > Depth ? Depth : n), rmax);
					count--;
				end
				if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(0, 20));
			end
		end

		pause_sender(0);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("covered %0d transactions: %0d swaps, %0d finished passes, %0d reads",
			sent, sb.swaps, sb.passes, sb.reads);
		if (sb.errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end
endmodule
